/* rtl/lgt_pkg.sv */
// Shared types and constants for the largest gap tracker.
package lgt_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int REPORT_N = (SLOTS < 16) ? SLOTS : 16;
    localparam int TS_W     = 63;
    localparam int CNT_W    = 64;
    localparam int THR_W    = 32;
    localparam int SLOT_OUT_W = 4;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = SLOT_OUT_W + 4 * TS_W + CNT_W;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd1000;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_DUMP   = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SCAN,
        ST_WRITE,
        ST_DUMP
    } t_state;

    typedef struct packed {
        logic [TS_W-1:0] gap_len;
        logic [TS_W-1:0] gap_stop;
        logic [TS_W-1:0] gap_start;
    } t_entry;

endpackage

/* rtl/largest_gap_tracker_unit.sv */
// Largest gap tracker: keeps the longest timestamp gaps in a slot memory and dumps them.
//
// Begin and ignored opcodes are handled in the idle state. A sample goes through accept, gap
// subtract, a read of each of the 16 slots over the slot memory's single read port to find the
// shortest stored gap (lowest slot on ties), and a write-back state. A dump is accepted
// and then sends 16 results, one per cycle while the output side
// is ready. The slot memory needs no clearing pass: a valid bit per slot, cleared at
// reset and on begin, makes an unwritten slot read as zero.
module largest_gap_tracker_unit
    import lgt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration: gap_threshold
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [THR_W-1:0]      i_cfg_data,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // timestamp[62:0], zero pad[63]
    input  logic [1:0]            s_axis_tuser,   // opcode[1:0]
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // slot[3:0], gap_start[66:4],
                                                  // gap_end[129:67], sample_count[193:130],
                                                  // first_time[256:194], last_time[319:257]
    output logic                  m_axis_tlast    // last_of_run
);

    t_state              r_state, n_state;
    logic [THR_W-1:0]    r_thr;
    logic [TS_W-1:0]     r_prev, n_prev;
    logic [TS_W-1:0]     r_first, n_first;
    logic [TS_W-1:0]     r_last, n_last;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TS_W-1:0]     r_ts, n_ts;
    logic [TS_W-1:0]     r_gap, n_gap;
    logic                r_pos, n_pos;
    logic [TS_W-1:0]     r_min_len, n_min_len;
    logic [SLOT_W-1:0]   r_min_idx, n_min_idx;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic [SLOTS-1:0]    r_valid, n_valid;

    t_entry              mem [SLOTS];
    t_entry              r_rd;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                wr_en;
    t_entry              wr_data;

    logic                r_o_valid, n_o_valid;
    logic                load_out;
    logic [SLOT_OUT_W-1:0] r_o_slot;
    logic [TS_W-1:0]     r_o_gap_start;
    logic [TS_W-1:0]     r_o_gap_end;
    logic [CNT_W-1:0]    r_o_count;
    logic [TS_W-1:0]     r_o_first;
    logic [TS_W-1:0]     r_o_last_time;
    logic                r_o_tlast;

    logic [TS_W-1:0]     in_ts;
    logic [TS_W:0]       diff_ext;
    logic [TS_W-1:0]     cur_len;
    logic                out_free;
    logic                dump_last;

    assign in_ts    = s_axis_tdata[TS_W-1:0];
    assign diff_ext = {1'b0, r_ts} - {1'b0, r_prev};
    assign cur_len  = r_valid[r_idx] ? r_rd.gap_len : '0;
    assign out_free = !r_o_valid || m_axis_tready;
    assign dump_last = (r_idx == SLOT_W'(REPORT_N - 1));

    assign wr_data.gap_start = r_prev;
    assign wr_data.gap_stop  = r_ts;
    assign wr_data.gap_len   = r_gap;

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tlast  = r_o_tlast;
    assign m_axis_tdata  = {r_o_last_time, r_o_first, r_o_count,
                            r_o_gap_end, r_o_gap_start, r_o_slot};

    always_comb begin
        n_state   = r_state;
        n_prev    = r_prev;
        n_first   = r_first;
        n_last    = r_last;
        n_count   = r_count;
        n_ts      = r_ts;
        n_gap     = r_gap;
        n_pos     = r_pos;
        n_min_len = r_min_len;
        n_min_idx = r_min_idx;
        n_idx     = r_idx;
        n_valid   = r_valid;
        rd_en     = 1'b0;
        rd_addr   = r_idx;
        wr_en     = 1'b0;
        load_out  = 1'b0;
        s_axis_tready = 1'b0;

        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    case (t_opcode'(s_axis_tuser))
                        OP_BEGIN: begin
                            n_first = in_ts;
                            n_prev  = in_ts;
                            n_count = '0;
                            n_valid = '0;
                        end
                        OP_SAMPLE: begin
                            n_count = r_count + CNT_W'(1);
                            n_ts    = in_ts;
                            n_state = ST_DIFF;
                        end
                        OP_DUMP: begin
                            n_last  = r_prev;
                            n_idx   = '0;
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = ST_DUMP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIFF: begin
                // borrow out means the timestamp went backwards
                n_gap   = diff_ext[TS_W-1:0];
                n_pos   = !diff_ext[TS_W] && (diff_ext[TS_W-1:0] != '0);
                n_idx   = '0;
                rd_en   = 1'b1;
                rd_addr = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if ((r_idx == '0) || (cur_len < r_min_len)) begin
                    n_min_len = cur_len;
                    n_min_idx = r_idx;
                end
                if (r_idx == SLOT_W'(SLOTS - 1)) begin
                    n_state = ST_WRITE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + SLOT_W'(1);
                    n_idx   = r_idx + SLOT_W'(1);
                end
            end
            ST_WRITE: begin
                if (r_pos && (r_gap > TS_W'(r_thr)) && (r_gap > r_min_len)) begin
                    wr_en = 1'b1;
                    n_valid[r_min_idx] = 1'b1;
                end
                n_prev  = r_ts;
                n_state = ST_IDLE;
            end
            ST_DUMP: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (dump_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx + SLOT_W'(1);
                        n_idx   = r_idx + SLOT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load_out) begin
            n_o_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_thr     <= THRESHOLD_RESET;
            r_prev    <= '0;
            r_first   <= '0;
            r_last    <= '0;
            r_count   <= '0;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            r_prev    <= n_prev;
            r_first   <= n_first;
            r_last    <= n_last;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ts      <= n_ts;
        r_gap     <= n_gap;
        r_pos     <= n_pos;
        r_min_len <= n_min_len;
        r_min_idx <= n_min_idx;
        r_idx     <= n_idx;
        if (load_out) begin
            r_o_slot      <= SLOT_OUT_W'(r_idx);
            r_o_gap_start <= r_valid[r_idx] ? r_rd.gap_start : '0;
            r_o_gap_end   <= r_valid[r_idx] ? r_rd.gap_stop : '0;
            r_o_count     <= r_count;
            r_o_first     <= r_first;
            r_o_last_time <= r_last;
            r_o_tlast     <= dump_last;
        end
    end

    // slot memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_min_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

endmodule

/* rtl/lgt_checker.sv */
// Port-level checker for the largest gap tracker, bound to largest_gap_tracker_unit.
module lgt_checker
    import lgt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [1:0]            s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result payload changed");

    // a sample or a dump occupies the block for at least the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tuser == OP_SAMPLE || s_axis_tuser == OP_DUMP) |=> !s_axis_tready)
        else $error("input accepted while previous transaction still in work");

    // the closing result of a dump reports the final slot
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
        m_axis_tdata[SLOT_OUT_W-1:0] == SLOT_OUT_W'(REPORT_N - 1))
        else $error("tlast on a slot other than the final one");

endmodule

bind largest_gap_tracker_unit lgt_checker u_lgt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* test/tb_top.sv */
// Testbench for largest_gap_tracker_unit: self-checking gap-table predictor and random streams.
`timescale 1ns / 1ps

module tb_top;
    import lgt_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         LIMIT_CYCLES = 2000000;
    localparam int         ITEM_TARGET  = 430;
    localparam int         MAX_PRINTED  = 40;

    localparam int GAP_START_LSB = SLOT_OUT_W;
    localparam int GAP_END_LSB   = GAP_START_LSB + TS_W;
    localparam int COUNT_LSB     = GAP_END_LSB + TS_W;
    localparam int FIRST_LSB     = COUNT_LSB + CNT_W;
    localparam int LAST_LSB      = FIRST_LSB + TS_W;

    typedef struct {
        logic [SLOT_OUT_W-1:0] slot;
        logic [TS_W-1:0]       gap_start;
        logic [TS_W-1:0]       gap_end;
        logic [CNT_W-1:0]      sample_count;
        logic [TS_W-1:0]       first_time;
        logic [TS_W-1:0]       last_time;
        logic                  last_of_run;
    } t_gap_report;

    // Tracks the gap table and holds the dump reports still owed by the block.
    class gap_table_model;
        logic [THR_W-1:0] threshold;
        logic [TS_W-1:0]  prev_ts;
        logic [TS_W-1:0]  first_ts;
        logic [TS_W-1:0]  last_ts;
        logic [CNT_W-1:0] samples;
        logic [TS_W-1:0]  slot_start [lgt_pkg::SLOTS];
        logic [TS_W-1:0]  slot_end   [lgt_pkg::SLOTS];
        t_gap_report      expected_reports [$];
        int unsigned      error_count;

        function new();
            threshold   = THRESHOLD_RESET;
            prev_ts     = '0;
            first_ts    = '0;
            last_ts     = '0;
            samples     = '0;
            error_count = 0;
            clear_slots();
        endfunction

        function void clear_slots();
            for (int k = 0; k < lgt_pkg::SLOTS; k++) begin
                slot_start[k] = '0;
                slot_end[k]   = '0;
            end
        endfunction

        function logic [TS_W-1:0] slot_length(int k);
            if (slot_end[k] > slot_start[k])
                return slot_end[k] - slot_start[k];
            return '0;
        endfunction

        function void set_threshold(logic [THR_W-1:0] value);
            threshold = value;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void note_item(logic [1:0] op, logic [TS_W-1:0] ts);
            int          shortest;
            t_gap_report rpt;
            logic [TS_W-1:0] gap;
            case (op)
                OP_BEGIN: begin
                    first_ts = ts;
                    prev_ts  = ts;
                    samples  = '0;
                    clear_slots();
                end
                OP_SAMPLE: begin
                    samples = samples + 1'b1;
                    if (ts > prev_ts) begin
                        gap = ts - prev_ts;
                        if (64'(gap) > 64'(threshold)) begin
                            // first-lowest-index shortest entry
                            shortest = 0;
                            for (int k = 1; k < lgt_pkg::SLOTS; k++)
                                if (slot_length(k) < slot_length(shortest))
                                    shortest = k;
                            if (gap > slot_length(shortest)) begin
                                slot_start[shortest] = prev_ts;
                                slot_end[shortest]   = ts;
                            end
                        end
                    end
                    prev_ts = ts;
                end
                OP_DUMP: begin
                    last_ts = prev_ts;
                    for (int k = 0; k < lgt_pkg::REPORT_N; k++) begin
                        rpt.slot         = SLOT_OUT_W'(k);
                        rpt.gap_start    = slot_start[k];
                        rpt.gap_end      = slot_end[k];
                        rpt.sample_count = samples;
                        rpt.first_time   = first_ts;
                        rpt.last_time    = last_ts;
                        rpt.last_of_run  = (k == lgt_pkg::REPORT_N - 1);
                        expected_reports.push_back(rpt);
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            if (error_count < MAX_PRINTED)
                $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got,
                         want);
            error_count++;
        endtask

        task check_report(t_gap_report got);
            t_gap_report want;
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected result slot", 64'(got.slot), 64'd0);
                return;
            end
            want = expected_reports.pop_front();
            if (got.slot != want.slot)
                report_mismatch("slot", 64'(got.slot), 64'(want.slot));
            if (got.gap_start != want.gap_start)
                report_mismatch("gap_start", 64'(got.gap_start), 64'(want.gap_start));
            if (got.gap_end != want.gap_end)
                report_mismatch("gap_end", 64'(got.gap_end), 64'(want.gap_end));
            if (got.sample_count != want.sample_count)
                report_mismatch("sample_count", got.sample_count, want.sample_count);
            if (got.first_time != want.first_time)
                report_mismatch("first_time", 64'(got.first_time), 64'(want.first_time));
            if (got.last_time != want.last_time)
                report_mismatch("last_time", 64'(got.last_time), 64'(want.last_time));
            if (got.last_of_run != want.last_of_run)
                report_mismatch("last_of_run", 64'(got.last_of_run), 64'(want.last_of_run));
        endtask
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [THR_W-1:0]      i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    gap_table_model gaps;
    int unsigned    items_sent    = 0;
    int unsigned    cycles        = 0;
    int unsigned    sink_hold     = 0;
    int unsigned    sink_pick;
    bit             source_steady = 1'b0;
    bit             sink_steady   = 1'b0;
    logic [THR_W-1:0] cur_thr     = THRESHOLD_RESET;
    logic [TS_W-1:0]  stim_ts     = '0;

    largest_gap_tracker_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_gap_report decode_report(logic [OUT_DATA_W-1:0] data, logic last);
        t_gap_report rpt;
        rpt.slot         = data[GAP_START_LSB-1:0];
        rpt.gap_start    = data[GAP_END_LSB-1:GAP_START_LSB];
        rpt.gap_end      = data[COUNT_LSB-1:GAP_END_LSB];
        rpt.sample_count = data[FIRST_LSB-1:COUNT_LSB];
        rpt.first_time   = data[LAST_LSB-1:FIRST_LSB];
        rpt.last_time    = data[LAST_LSB+TS_W-1:LAST_LSB];
        rpt.last_of_run  = last;
        return rpt;
    endfunction

    // Result side: check each transaction, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            gaps.check_report(decode_report(m_axis_tdata, m_axis_tlast));
        if (sink_hold != 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!sink_steady) begin
                sink_pick = $urandom_range(0, 99);
                if (sink_pick < 15)
                    sink_hold = $urandom_range(1, 3);
                else if (sink_pick < 18)
                    sink_hold = $urandom_range(12, 40);
            end
        end
    end

    function automatic logic [TS_W-1:0] rand_ts();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TS_W-1:0];
    endfunction

    function automatic logic [TS_W-1:0] next_sample_ts(logic [TS_W-1:0] prev,
                                                       logic [THR_W-1:0] thr);
        logic [63:0] step;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return rand_ts();
        if (pick == 1)
            return prev - TS_W'($urandom_range(1, 100000));
        if (pick < 5)
            step = 64'($urandom_range(0, thr));
        else if (pick < 12)
            step = 64'(thr) + 64'($urandom_range(1, 4));   // near ties
        else
            step = 64'(thr) + 64'($urandom_range(1, 200000));
        return prev + step[TS_W-1:0];
    endfunction

    task automatic source_pause();
        int unsigned n;
        int unsigned pick;
        n = 0;
        if (!source_steady) begin
            pick = $urandom_range(0, 99);
            if (pick >= 92)
                n = $urandom_range(8, 30);
            else if (pick >= 60)
                n = $urandom_range(1, 3);
        end
        if (n != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold valid after the transaction so a back-to-back item needs no toggle.
    task automatic send_item(logic [1:0] op, logic [TS_W-1:0] ts);
        source_pause();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, ts};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        gaps.note_item(op, ts);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic send_sample(logic [TS_W-1:0] ts);
        send_item(OP_SAMPLE, ts);
        stim_ts = ts;
    endtask

    task automatic send_begin(logic [TS_W-1:0] ts);
        send_item(OP_BEGIN, ts);
        stim_ts = ts;
    endtask

    // Drop valid, let all reports arrive, then cover a sample still in flight.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (gaps.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        wait_for_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        gaps.set_threshold(value);
        cur_thr = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return THRESHOLD_RESET;
            3:       return $urandom;
            default: return THR_W'($urandom_range(1, 3000));
        endcase
    endfunction

    initial begin
        int unsigned n;
        gaps = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // samples before any begin measure from zero; backwards stamp; unused opcode
        send_sample(TS_W'(5000));
        send_sample(TS_W'(3000));
        send_item(OP_UNUSED, rand_ts());
        send_item(OP_DUMP, '0);
        // dump right after begin, then backwards and maximal gaps
        send_begin('1);
        send_item(OP_DUMP, '1);
        send_sample('0);
        send_sample('1);
        send_sample('1);
        send_item(OP_DUMP, rand_ts());

        write_threshold('0);
        send_begin(TS_W'(100));
        for (int k = 0; k < 11; k++)
            send_sample(stim_ts + TS_W'(k % 3));
        send_item(OP_DUMP, rand_ts());

        // samples after a dump keep accumulating; one gap just over, one at the limit
        write_threshold('1);
        send_sample(stim_ts + TS_W'(64'h1_0000_0000));
        send_sample(stim_ts + TS_W'(64'hFFFF_FFFF));
        send_item(OP_DUMP, rand_ts());

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 1) == 0)
                write_threshold(pick_threshold());
            source_steady = ($urandom_range(0, 4) == 0);
            sink_steady   = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) != 0) begin
                if ($urandom_range(0, 3) == 0)
                    send_begin(rand_ts());
                else
                    send_begin(TS_W'({$urandom_range(0, 255), $urandom}));
            end
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 20);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 24) == 0)
                    send_item(OP_UNUSED, rand_ts());
                send_sample(next_sample_ts(stim_ts, cur_thr));
            end
            send_item(OP_DUMP, rand_ts());
            if ($urandom_range(0, 5) == 0) begin
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                    send_sample(next_sample_ts(stim_ts, cur_thr));
                send_item(OP_DUMP, rand_ts());
            end
        end

        wait_for_drain();
        if (gaps.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
rtl/lgt_pkg.sv
rtl/largest_gap_tracker_unit.sv
rtl/lgt_checker.sv
test/tb_top.sv
